// ===== rtl/tsp_pkg.sv =====
package tsp_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic               first;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] earlier_index;
    logic [15:0] current_index;
  } out_item_t;

  // control bits of the search token that walks the cell row
  typedef struct packed {
    logic valid;
    logic hit;
    logic same;
  } tok_ctl_t;

  // table write command broadcast to the row
  typedef struct packed {
    logic append;
    logic reindex;
  } wr_ctl_t;

  localparam logic [2:0] ST_NO_PAIR  = 3'd0;
  localparam logic [2:0] ST_PAIR     = 3'd1;
  localparam logic [2:0] ST_IGNORED  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  localparam logic [16:0] INDEX_LIMIT = 17'h10000;

endpackage

// ===== rtl/tsp_cell.sv =====
module tsp_cell #(
  parameter int VALUE_BITS = 32,
  parameter int SLOT_BITS  = 6,
  parameter int SLOT_ID    = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           clear,
  input  tsp_pkg::wr_ctl_t               wr_ctl,
  input  logic [SLOT_BITS-1:0]           wr_slot,
  input  logic [VALUE_BITS-1:0]          wr_value,
  input  logic [15:0]                    wr_index,
  input  tsp_pkg::tok_ctl_t              in_ctl,
  input  logic [VALUE_BITS-1:0]          in_val,
  input  logic [VALUE_BITS:0]            in_gap,
  input  logic [15:0]                    in_hit_index,
  input  logic [SLOT_BITS-1:0]           in_same_slot,
  output tsp_pkg::tok_ctl_t              out_ctl,
  output logic [VALUE_BITS-1:0]          out_val,
  output logic [VALUE_BITS:0]            out_gap,
  output logic [15:0]                    out_hit_index,
  output logic [SLOT_BITS-1:0]           out_same_slot
);
  import tsp_pkg::*;

  localparam logic [SLOT_BITS-1:0] MY_SLOT = SLOT_BITS'(SLOT_ID);

  logic [VALUE_BITS-1:0] entry_value;
  logic [15:0]           entry_index;
  logic                  entry_valid;
  logic [VALUE_BITS:0]   value_ext;
  logic                  gap_match;
  logic                  same_match;
  logic                  slot_sel;

  assign value_ext  = {entry_value[VALUE_BITS-1], entry_value};
  assign gap_match  = entry_valid && (value_ext == in_gap);
  assign same_match = entry_valid && (entry_value == in_val);
  assign slot_sel   = (wr_slot == MY_SLOT);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (clear) begin
      entry_valid <= 1'b0;
    end else if (wr_ctl.append && slot_sel) begin
      entry_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_sel && (wr_ctl.append || wr_ctl.reindex)) begin
      entry_index <= wr_index;
    end
    if (slot_sel && wr_ctl.append) begin
      entry_value <= wr_value;
    end
  end

  // token stage: first match along the row wins
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl.valid <= in_ctl.valid;
      out_ctl.hit   <= in_ctl.hit || gap_match;
      out_ctl.same  <= in_ctl.same || same_match;
    end
    out_val       <= in_val;
    out_gap       <= in_gap;
    out_hit_index <= in_ctl.hit ? in_hit_index : entry_index;
    out_same_slot <= in_ctl.same ? in_same_slot : MY_SLOT;
  end

endmodule

// ===== rtl/tsp_chain.sv =====
module tsp_chain #(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_BITS  = 32,
  parameter int SLOT_BITS   = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  tsp_pkg::wr_ctl_t      wr_ctl,
  input  logic [SLOT_BITS-1:0]  wr_slot,
  input  logic [VALUE_BITS-1:0] wr_value,
  input  logic [15:0]           wr_index,
  input  tsp_pkg::tok_ctl_t     head_ctl,
  input  logic [VALUE_BITS-1:0] head_val,
  input  logic [VALUE_BITS:0]   head_gap,
  output tsp_pkg::tok_ctl_t     tail_ctl,
  output logic [VALUE_BITS-1:0] tail_val,
  output logic [15:0]           tail_hit_index,
  output logic [SLOT_BITS-1:0]  tail_same_slot
);
  import tsp_pkg::*;

  tok_ctl_t              tok_ctl       [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] tok_val       [TABLE_DEPTH];
  logic [VALUE_BITS:0]   tok_gap       [TABLE_DEPTH];
  logic [15:0]           tok_hit_index [TABLE_DEPTH];
  logic [SLOT_BITS-1:0]  tok_same_slot [TABLE_DEPTH];

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    tok_ctl_t              c_ctl;
    logic [VALUE_BITS-1:0] c_val;
    logic [VALUE_BITS:0]   c_gap;
    logic [15:0]           c_hit_index;
    logic [SLOT_BITS-1:0]  c_same_slot;

    if (i == 0) begin : g_head
      assign c_ctl       = head_ctl;
      assign c_val       = head_val;
      assign c_gap       = head_gap;
      assign c_hit_index = '0;
      assign c_same_slot = '0;
    end else begin : g_link
      assign c_ctl       = tok_ctl[i-1];
      assign c_val       = tok_val[i-1];
      assign c_gap       = tok_gap[i-1];
      assign c_hit_index = tok_hit_index[i-1];
      assign c_same_slot = tok_same_slot[i-1];
    end

    tsp_cell #(
      .VALUE_BITS (VALUE_BITS),
      .SLOT_BITS  (SLOT_BITS),
      .SLOT_ID    (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .clear         (clear),
      .wr_ctl        (wr_ctl),
      .wr_slot       (wr_slot),
      .wr_value      (wr_value),
      .wr_index      (wr_index),
      .in_ctl        (c_ctl),
      .in_val        (c_val),
      .in_gap        (c_gap),
      .in_hit_index  (c_hit_index),
      .in_same_slot  (c_same_slot),
      .out_ctl       (tok_ctl[i]),
      .out_val       (tok_val[i]),
      .out_gap       (tok_gap[i]),
      .out_hit_index (tok_hit_index[i]),
      .out_same_slot (tok_same_slot[i])
    );
  end

  assign tail_ctl       = tok_ctl[TABLE_DEPTH-1];
  assign tail_val       = tok_val[TABLE_DEPTH-1];
  assign tail_hit_index = tok_hit_index[TABLE_DEPTH-1];
  assign tail_same_slot = tok_same_slot[TABLE_DEPTH-1];

endmodule

// ===== rtl/two_sum_pair_finder_core.sv =====
// Streaming two-sum search. Each input request carries a signed value and a
// "first" flag that opens a new sequence (table, index and done flag cleared).
// Each request produces exactly one result: status, earlier index on a pair,
// and the request's index within its sequence.
// cfg_wr_en/cfg_wr_data load target_sum; write it only while the block is idle.
// Input and output use valid/stall; a request is taken when valid is high and
// stall is low.
// Search: a searched request walks a token through the row of TABLE_DEPTH
// table cells, one cell per cycle, from the head register through each cell
// to the result register; no new request is taken until that result is in
// the output register. Requests that arrive after a pair was found, or past
// index 65535, skip the walk and run at one per cycle while out_stall is low.
// A finished result sits in the output register; while out_stall is high the
// block holds it and stalls input. A walk already under way finishes and
// waits for the output register to free up.
// Reset (synchronous) empties the table, zeroes target_sum and the index
// counter, and drops both valids; no clearing pass is needed.
module two_sum_pair_finder_core #(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  tsp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tsp_pkg::out_item_t out_data
);
  import tsp_pkg::*;

  localparam int SLOT_BITS  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(TABLE_DEPTH + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(TABLE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FINISH} state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] target_sum;
  logic [16:0]           next_index;
  logic [COUNT_BITS-1:0] entry_count;
  logic                  pair_done;
  logic [15:0]           cur_index;
  out_item_t             result;

  tok_ctl_t              head_ctl;
  logic [VALUE_BITS-1:0] head_val;
  logic [VALUE_BITS:0]   head_gap;
  tok_ctl_t              tail_ctl;
  logic [VALUE_BITS-1:0] tail_val;
  logic [15:0]           tail_hit_index;
  logic [SLOT_BITS-1:0]  tail_same_slot;

  wr_ctl_t               wr_ctl;
  logic [SLOT_BITS-1:0]  wr_slot;
  logic [VALUE_BITS-1:0] wr_value;
  logic [15:0]           wr_index;

  logic                  in_acc;
  logic                  out_free;
  logic                  seq_clear;
  logic [16:0]           idx_eff;
  logic [16:0]           idx_next;
  logic [COUNT_BITS-1:0] count_eff;
  logic                  done_eff;
  logic [15:0]           cur_eff;
  logic [VALUE_BITS-1:0] val_in;
  logic [VALUE_BITS:0]   gap_in;

  assign in_stall  = (state != S_IDLE) || (out_valid && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign seq_clear = in_acc && in_data.first;

  always_comb begin
    idx_eff   = in_data.first ? '0 : next_index;
    count_eff = in_data.first ? '0 : entry_count;
    done_eff  = in_data.first ? 1'b0 : pair_done;
    idx_next  = idx_eff[16] ? idx_eff : idx_eff + 17'd1;
    cur_eff   = idx_eff[16] ? 16'hFFFF : idx_eff[15:0];
    val_in    = in_data.value[VALUE_BITS-1:0];
    // one bit wider than a value, so an unreachable gap never matches
    gap_in    = {target_sum[VALUE_BITS-1], target_sum} - {val_in[VALUE_BITS-1], val_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      target_sum  <= '0;
      next_index  <= '0;
      entry_count <= '0;
      pair_done   <= 1'b0;
      out_valid   <= 1'b0;
      head_ctl    <= '0;
      wr_ctl      <= '0;
    end else begin
      head_ctl <= '0;
      wr_ctl   <= '0;
      if (cfg_wr_en) begin
        target_sum <= cfg_wr_data[VALUE_BITS-1:0];
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            next_index  <= idx_next;
            entry_count <= count_eff;
            pair_done   <= done_eff;
            cur_index   <= cur_eff;
            if (done_eff || idx_eff >= INDEX_LIMIT) begin
              out_valid              <= 1'b1;
              out_data.status        <= done_eff ? ST_IGNORED : ST_TOO_LONG;
              out_data.earlier_index <= '0;
              out_data.current_index <= cur_eff;
            end else begin
              head_ctl.valid <= 1'b1;
              head_val       <= val_in;
              head_gap       <= gap_in;
              state          <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (tail_ctl.valid) begin
            result.current_index <= cur_index;
            result.earlier_index <= '0;
            result.status        <= ST_NO_PAIR;
            wr_value             <= tail_val;
            wr_index             <= cur_index;
            if (tail_ctl.hit) begin
              result.status        <= ST_PAIR;
              result.earlier_index <= tail_hit_index;
              pair_done            <= 1'b1;
            end else if (tail_ctl.same) begin
              wr_ctl.reindex <= 1'b1;
              wr_slot        <= tail_same_slot;
            end else if (entry_count < COUNT_MAX) begin
              // entries fill in order, so the first free slot is the count
              wr_ctl.append <= 1'b1;
              wr_slot       <= entry_count[SLOT_BITS-1:0];
              entry_count   <= entry_count + COUNT_BITS'(1);
            end else begin
              result.status <= ST_FULL;
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= result;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  tsp_chain #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS),
    .SLOT_BITS   (SLOT_BITS)
  ) u_chain (
    .clk            (clk),
    .rst            (rst),
    .clear          (seq_clear),
    .wr_ctl         (wr_ctl),
    .wr_slot        (wr_slot),
    .wr_value       (wr_value),
    .wr_index       (wr_index),
    .head_ctl       (head_ctl),
    .head_val       (head_val),
    .head_gap       (head_gap),
    .tail_ctl       (tail_ctl),
    .tail_val       (tail_val),
    .tail_hit_index (tail_hit_index),
    .tail_same_slot (tail_same_slot)
  );

  a_tail_in_walk: assert property (@(posedge clk) disable iff (rst)
    tail_ctl.valid |-> state == S_WALK)
    else $error("search token left the row outside a walk");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= COUNT_MAX)
    else $error("entry count above table depth");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(wr_ctl.append && wr_ctl.reindex))
    else $error("append and reindex issued together");

  a_index_sat: assert property (@(posedge clk) disable iff (rst)
    next_index <= INDEX_LIMIT)
    else $error("index counter past saturation");

  a_walk_no_output_load: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK && !tail_ctl.valid |=> !$rose(out_valid))
    else $error("result loaded while search still running");

endmodule
